[rtl/arqrx_pkg.sv]
// Package with the packet layout constants, event codes and CRC-16 functions of the ARQ receiver.
package arqrx_pkg;

    localparam int DATA_BYTES = 8;
    localparam int RING_SLOTS = 16;
    localparam int HDR_BYTES  = 4;
    localparam int PKT_BYTES  = HDR_BYTES + DATA_BYTES + 2;
    localparam int CNT_W      = $clog2(PKT_BYTES);
    localparam int PAY_IDX_W  = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

    localparam logic [15:0] CRC_POLY = 16'h2110;

    typedef enum logic [2:0] {
        EV_CRC_BAD  = 3'd0,
        EV_ACK_RX   = 3'd1,
        EV_NACK_RX  = 3'd2,
        EV_DATA_OK  = 3'd3,
        EV_OUT_SEQ  = 3'd4
    } t_event;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NACK = 2'd2;

    localparam logic [15:0] TYPE_ACK  = 16'd1;
    localparam logic [15:0] TYPE_NACK = 16'd2;

    typedef logic [31:0][15:0] t_crc_cols;

    // One byte through the MSB-first CRC register, message bits shifted in at the bottom.
    function automatic logic [15:0] crc_byte(logic [15:0] rem, logic [7:0] b);
        logic [15:0] r;
        logic        top;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            top = r[15];
            r   = {r[14:0], b[i]};
            if (top) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // The reply CRC starts from zero, so it is linear in the header bits. Each column
    // is the CRC of a reply whose header has a single bit set.
    function automatic t_crc_cols build_cols();
        t_crc_cols   cols;
        logic [15:0] r;
        logic [31:0] hdr;
        for (int k = 0; k < 32; k++) begin
            r   = 16'h0000;
            hdr = 32'h1 << k;
            for (int j = 0; j < HDR_BYTES; j++) begin
                r = crc_byte(r, hdr[8*j +: 8]);
            end
            for (int j = 0; j < DATA_BYTES + 2; j++) begin
                r = crc_byte(r, 8'h00);
            end
            cols[k] = r;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = build_cols();

    // Header is {seq, type}, little-endian on the wire.
    function automatic logic [15:0] reply_crc(logic [31:0] hdr);
        logic [15:0] r;
        r = 16'h0000;
        for (int k = 0; k < 32; k++) begin
            if (hdr[k]) begin
                r = r ^ CRC_COLS[k];
            end
        end
        return r;
    endfunction

endpackage

[rtl/arq_packet_receiver_top.sv]
// Top level of the ARQ packet receiver: packet assembly, CRC check and reply generation.
//
//  Channel | Valid       | Ready       | Payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_rx_byte
//  out     | o_out_valid | i_out_ready | o_event_res, o_packet_seq, o_payload,
//          |             |             | o_ring_slot, o_reply_valid/type/seq/crc
//
// One byte is taken per cycle unless the last byte stalls; the CRC step and header bookkeeping finish in that cycle.
// The last byte of a packet places its result in the output register, which presents it in the following cycle.
// Reset (synchronous, active low) clears the byte count, CRC, header, payload and
// expected sequence number.
// Only the last byte of a packet stalls, and only while the previous result is still
// waiting to be taken; all other bytes are accepted regardless of the output side.
module arq_packet_receiver_top
    import arqrx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_packet_seq,
    output logic [63:0] o_payload,
    output logic [3:0]  o_ring_slot,
    output logic        o_reply_valid,
    output logic [1:0]  o_reply_type,
    output logic [15:0] o_reply_seq,
    output logic [15:0] o_reply_crc
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [15:0]       r_crc, n_crc;
    logic [31:0]       r_header, n_header;
    logic [63:0]       r_payload, n_payload;
    logic [15:0]       r_exp_seq, n_exp_seq;
    logic [SLOT_W-1:0] r_exp_slot, n_exp_slot;

    logic              r_out_valid;
    t_event            r_event, n_event;
    logic [15:0]       r_pkt_seq;
    logic [63:0]       r_out_payload;
    logic [3:0]        r_slot, n_slot;
    logic              r_rep_valid, n_rep_valid;
    logic [1:0]        r_rep_type, n_rep_type;
    logic [15:0]       r_rep_seq, n_rep_seq;
    logic [15:0]       r_rep_crc, n_rep_crc;

    logic                 last_byte;
    logic                 in_xfer;
    logic [15:0]          pkt_type;
    logic [15:0]          pkt_seq;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic [CNT_W-1:0]     cnt_m4;

    assign last_byte  = (r_count == CNT_W'(PKT_BYTES - 1));
    assign o_in_ready = !last_byte || !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign pkt_type   = r_header[15:0];
    assign pkt_seq    = r_header[31:16];
    assign cnt_m4     = r_count - CNT_W'(HDR_BYTES);
    assign pay_idx    = cnt_m4[PAY_IDX_W-1:0];

    // Byte assembly and running CRC.
    always_comb begin
        n_count   = r_count;
        n_crc     = r_crc;
        n_header  = r_header;
        n_payload = r_payload;
        if (in_xfer) begin
            if (last_byte) begin
                n_count   = '0;
                n_crc     = 16'h0000;
                n_header  = '0;
                n_payload = '0;
            end else begin
                n_count = r_count + CNT_W'(1);
                n_crc   = crc_byte(r_crc, i_rx_byte);
                if (r_count < CNT_W'(HDR_BYTES)) begin
                    n_header[8*r_count[1:0] +: 8] = i_rx_byte;
                end else if (r_count < CNT_W'(HDR_BYTES + DATA_BYTES)) begin
                    n_payload[8*pay_idx +: 8] = i_rx_byte;
                end
            end
        end
    end

    // Packet classification on the final CRC byte.
    always_comb begin
        logic [15:0] final_crc;
        final_crc   = crc_byte(r_crc, i_rx_byte);
        n_exp_seq   = r_exp_seq;
        n_exp_slot  = r_exp_slot;
        n_slot      = 4'd0;
        n_rep_valid = 1'b0;
        n_rep_type  = REPLY_NONE;
        n_rep_seq   = 16'h0000;
        priority if (final_crc != 16'h0000) begin
            n_event = EV_CRC_BAD;
        end else if (pkt_type == TYPE_ACK) begin
            n_event = EV_ACK_RX;
        end else if (pkt_type == TYPE_NACK) begin
            n_event = EV_NACK_RX;
        end else if (pkt_seq == r_exp_seq) begin
            n_event     = EV_DATA_OK;
            n_slot      = 4'(r_exp_slot);
            n_rep_valid = 1'b1;
            n_rep_type  = REPLY_ACK;
            n_rep_seq   = pkt_seq;
            n_exp_seq   = r_exp_seq + 16'd1;
            // The slot follows the expected number modulo the slot count and
            // restarts at zero when the sequence number wraps.
            if (r_exp_seq == 16'hFFFF || r_exp_slot == SLOT_W'(RING_SLOTS - 1)) begin
                n_exp_slot = '0;
            end else begin
                n_exp_slot = r_exp_slot + SLOT_W'(1);
            end
        end else begin
            n_event     = EV_OUT_SEQ;
            n_rep_valid = 1'b1;
            n_rep_type  = REPLY_NACK;
            n_rep_seq   = r_exp_seq;
        end
        n_rep_crc = n_rep_valid ? reply_crc({n_rep_seq, 14'd0, n_rep_type}) : 16'h0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= 16'h0000;
            r_header   <= '0;
            r_payload  <= '0;
            r_exp_seq  <= 16'h0000;
            r_exp_slot <= '0;
        end else begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_header  <= n_header;
            r_payload <= n_payload;
            if (in_xfer && last_byte) begin
                r_exp_seq  <= n_exp_seq;
                r_exp_slot <= n_exp_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && last_byte) begin
            r_event       <= n_event;
            r_pkt_seq     <= pkt_seq;
            r_out_payload <= r_payload;
            r_slot        <= n_slot;
            r_rep_valid   <= n_rep_valid;
            r_rep_type    <= n_rep_type;
            r_rep_seq     <= n_rep_seq;
            r_rep_crc     <= n_rep_crc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_event;
    assign o_packet_seq  = r_pkt_seq;
    assign o_payload     = r_out_payload;
    assign o_ring_slot   = r_slot;
    assign o_reply_valid = r_rep_valid;
    assign o_reply_type  = r_rep_type;
    assign o_reply_seq   = r_rep_seq;
    assign o_reply_crc   = r_rep_crc;

    // A stalled input can only be the last byte of a packet facing a full output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (last_byte && r_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    // The final byte of a packet always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && last_byte) |=> (o_out_valid && r_count == '0))
        else $error("completed packet did not produce a result");

    // Replies go out exactly for accepted and out-of-order data packets.
    a_reply_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reply_valid ==
            (o_event_res == EV_DATA_OK || o_event_res == EV_OUT_SEQ)))
        else $error("reply flag disagrees with event");

    // The expected sequence number moves only on an accepted data transfer.
    a_exp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_seq != $past(r_exp_seq)) |-> (o_out_valid && o_event_res == EV_DATA_OK
            && r_exp_seq == o_packet_seq + 16'd1))
        else $error("expected sequence number changed without accepted data");

    // The byte counter stays within one packet.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PKT_BYTES - 1))
        else $error("byte counter out of range");

endmodule
